### design/assert_macros.svh
// assertion macros shared by the segment intersection rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, expr) \
    label: assert property (@(posedge clk) (expr)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_ALWAYS(label, clk, expr)
`endif
`endif

### design/sint_pkg.sv
// shared constants and types for the segment intersection pipeline
// no dependencies
package sint_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef struct packed {
        logic valid;
        logic bad;
        logic neg_x;
        logic neg_y;
    } ctrl_t;
endpackage

### design/sint_front.sv
// front stages: differences, cross products, denominator, scaled numerators
// uses sint_pkg and assert_macros.svh
module sint_front #(
    parameter int C = sint_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      ce,
    input  logic                      in_valid,
    input  logic [8*C-1:0]            in_data,
    output sint_pkg::ctrl_t           out_ctrl,
    output logic [3*C+4:0]            out_prod_x,
    output logic [3*C+4:0]            out_prod_y,
    output logic [2*C+3:0]            out_den,
    output logic signed [C-1:0]       out_ax,
    output logic signed [C-1:0]       out_ay
);
    localparam int D   = C + 1;
    localparam int PW  = 2 * D;
    localparam int XW  = PW + 1;
    localparam int NUW = PW + 2;
    localparam int PRW = NUW + D;

    logic signed [C-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    assign ax = in_data[0*C +: C];
    assign ay = in_data[1*C +: C];
    assign bx = in_data[2*C +: C];
    assign by = in_data[3*C +: C];
    assign cx = in_data[4*C +: C];
    assign cy = in_data[5*C +: C];
    assign dx = in_data[6*C +: C];
    assign dy = in_data[7*C +: C];

    // stage 1
    logic v1_reg, bad1_reg;
    logic signed [D-1:0] ux1_reg, uy1_reg, vx1_reg, vy1_reg, wx1_reg, wy1_reg;
    logic signed [C-1:0] ax1_reg, ay1_reg;
    logic bad1_next;
    assign bad1_next = (ax == bx && ay == by) || (cx == dx && cy == dy)
        || (ax == cx && ay == cy) || (bx == cx && by == cy)
        || (ax == dx && ay == dy) || (bx == dx && by == dy);

    // stage 2
    logic v2_reg, bad2_reg;
    logic signed [PW-1:0] p_uxvy_reg, p_uyvx_reg, p_uxwy_reg, p_uywx_reg;
    logic signed [PW-1:0] p_vxwy_reg, p_vywx_reg;
    logic signed [D-1:0] ux2_reg, uy2_reg;
    logic signed [C-1:0] ax2_reg, ay2_reg;

    // stage 3
    logic v3_reg, bad3_reg;
    logic signed [XW-1:0] crc3_reg, crd3_reg, num3_reg;
    logic signed [D-1:0] ux3_reg, uy3_reg;
    logic signed [C-1:0] ax3_reg, ay3_reg;
    logic signed [XW-1:0] crc_next, crd_next;
    assign crc_next = XW'(p_uxvy_reg) - XW'(p_uyvx_reg);
    assign crd_next = XW'(p_uxwy_reg) - XW'(p_uywx_reg);

    // stage 4
    logic v4_reg, bad4_reg;
    logic signed [NUW-1:0] den4_reg, num4_reg;
    logic signed [D-1:0] ux4_reg, uy4_reg;
    logic signed [C-1:0] ax4_reg, ay4_reg;
    logic signed [NUW-1:0] den_raw;
    assign den_raw = NUW'(crd3_reg) - NUW'(crc3_reg);

    // stage 5
    logic v5_reg, bad5_reg, negx5_reg, negy5_reg;
    logic bad5_next;
    logic [NUW-1:0] num5, den5;
    logic [D-1:0] magx, magy;
    logic [PRW-1:0] prodx_next, prody_next;
    assign bad5_next = bad4_reg || num4_reg < 0 || num4_reg > den4_reg;
    assign num5 = bad5_next ? '0 : num4_reg;
    assign den5 = bad5_next ? NUW'(1) : den4_reg;
    assign magx = ux4_reg[D-1] ? D'(-ux4_reg) : D'(ux4_reg);
    assign magy = uy4_reg[D-1] ? D'(-uy4_reg) : D'(uy4_reg);
    assign prodx_next = PRW'(num5) * PRW'(magx);
    assign prody_next = PRW'(num5) * PRW'(magy);

    assign out_ctrl = '{valid: v5_reg, bad: bad5_reg, neg_x: negx5_reg, neg_y: negy5_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            bad1_reg <= bad1_next;
            ux1_reg <= D'(bx) - D'(ax);
            uy1_reg <= D'(by) - D'(ay);
            vx1_reg <= D'(cx) - D'(ax);
            vy1_reg <= D'(cy) - D'(ay);
            wx1_reg <= D'(dx) - D'(ax);
            wy1_reg <= D'(dy) - D'(ay);
            ax1_reg <= ax;
            ay1_reg <= ay;

            bad2_reg <= bad1_reg;
            p_uxvy_reg <= PW'(ux1_reg) * PW'(vy1_reg);
            p_uyvx_reg <= PW'(uy1_reg) * PW'(vx1_reg);
            p_uxwy_reg <= PW'(ux1_reg) * PW'(wy1_reg);
            p_uywx_reg <= PW'(uy1_reg) * PW'(wx1_reg);
            p_vxwy_reg <= PW'(vx1_reg) * PW'(wy1_reg);
            p_vywx_reg <= PW'(vy1_reg) * PW'(wx1_reg);
            ux2_reg <= ux1_reg;
            uy2_reg <= uy1_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;

            // same side of line ab, on-line counts as non-negative
            bad3_reg <= bad2_reg || (crc_next[XW-1] == crd_next[XW-1]);
            crc3_reg <= crc_next;
            crd3_reg <= crd_next;
            num3_reg <= XW'(p_vxwy_reg) - XW'(p_vywx_reg);
            ux3_reg <= ux2_reg;
            uy3_reg <= uy2_reg;
            ax3_reg <= ax2_reg;
            ay3_reg <= ay2_reg;

            bad4_reg <= bad3_reg;
            den4_reg <= den_raw[NUW-1] ? -den_raw : den_raw;
            num4_reg <= den_raw[NUW-1] ? -NUW'(num3_reg) : NUW'(num3_reg);
            ux4_reg <= ux3_reg;
            uy4_reg <= uy3_reg;
            ax4_reg <= ax3_reg;
            ay4_reg <= ay3_reg;

            bad5_reg <= bad5_next;
            negx5_reg <= ux4_reg[D-1];
            negy5_reg <= uy4_reg[D-1];
            out_prod_x <= prodx_next;
            out_prod_y <= prody_next;
            out_den <= den5;
            out_ax <= ax4_reg;
            out_ay <= ay4_reg;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_den_pos, aclk, aresetn, out_ctrl.valid, out_den != '0)
    `ASSERT_IMPLIES(a_bad_zero, aclk, aresetn, out_ctrl.valid && out_ctrl.bad,
                    out_prod_x == '0 && out_prod_y == '0)
endmodule

### design/sint_div.sv
// pipelined restoring divider, one quotient bit per register stage
// uses assert_macros.svh
module sint_div #(
    parameter int NUW = 36,
    parameter int QW  = 25,
    parameter int SW  = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic [NUW+QW-1:0]    in_dividend,
    input  logic [NUW-1:0]       in_den,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic [QW-1:0]        out_q,
    output logic                 out_rem_nz,
    output logic [SW-1:0]        out_side
);
    logic [NUW-1:0] rem_reg  [0:QW];
    logic [NUW-1:0] den_reg  [0:QW];
    logic [QW-1:0]  low_reg  [0:QW];
    logic [QW-1:0]  q_reg    [0:QW];
    logic [SW-1:0]  side_reg [0:QW];
    logic           valid_reg[0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (ce) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= in_dividend[NUW+QW-1:QW];
            low_reg[0]  <= in_dividend[QW-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [NUW:0] trial;
        logic [NUW:0] diff;
        logic         ge;
        assign trial = {rem_reg[i], low_reg[i][QW-1]};
        assign diff  = trial - {1'b0, den_reg[i]};
        assign ge    = trial >= {1'b0, den_reg[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i+1]  <= ge ? diff[NUW-1:0] : trial[NUW-1:0];
                low_reg[i+1]  <= {low_reg[i][QW-2:0], 1'b0};
                q_reg[i+1]    <= {q_reg[i][QW-2:0], ge};
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid  = valid_reg[QW];
    assign out_q      = q_reg[QW];
    assign out_rem_nz = rem_reg[QW] != '0;
    assign out_side   = side_reg[QW];

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_rem_below_den, aclk, aresetn, valid_reg[QW], rem_reg[QW] < den_reg[QW])
    `ASSERT_IMPLIES(a_rem_in_below, aclk, aresetn, valid_reg[0], rem_reg[0] < den_reg[0])
endmodule

### design/segment_intersection_2d.sv
// top level of the 2d segment intersection pipeline
// uses sint_pkg, sint_front, sint_div and assert_macros.svh
// Fully pipelined: one transfer can be taken every cycle while the pipeline
// advances; each result passes through the five front stages, the divider load
// stage, one divider stage per quotient bit (COORD_BITS + FRAC_BITS + 1) and the
// output register. The whole pipeline advances
// whenever the output register is empty or being taken, so s_tready follows
// m_tready. hit travels in m_tuser; without a hit both coordinates are zero.
module segment_intersection_2d #(
    parameter int COORD_BITS = sint_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sint_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [8*COORD_BITS-1:0]   s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // hit_x, hit_y, zero fill
    output logic [((2*(COORD_BITS+FRAC_BITS)+7)/8)*8-1:0] m_tdata,
    // hit
    output logic                      m_tuser
);
    localparam int C   = COORD_BITS;
    localparam int D   = C + 1;
    localparam int NUW = 2 * D + 2;
    localparam int QW  = D + FRAC_BITS;
    localparam int OW  = C + FRAC_BITS;
    localparam int EW  = OW + 2;
    localparam int TW  = ((2 * OW + 7) / 8) * 8;
    localparam int SW  = 2 * C + 2;

    logic ce;
    sint_pkg::ctrl_t f_ctrl;
    logic [NUW+D-1:0] f_prod_x, f_prod_y;
    logic [NUW-1:0]   f_den;
    logic signed [C-1:0] f_ax, f_ay;

    assign ce = !m_tvalid || m_tready;
    assign s_tready = ce;

    sint_front #(.C(C)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .out_ctrl   (f_ctrl),
        .out_prod_x (f_prod_x),
        .out_prod_y (f_prod_y),
        .out_den    (f_den),
        .out_ax     (f_ax),
        .out_ay     (f_ay)
    );

    logic [NUW+QW-1:0] dvd_x, dvd_y;
    assign dvd_x = (NUW+QW)'(f_prod_x) << FRAC_BITS;
    assign dvd_y = (NUW+QW)'(f_prod_y) << FRAC_BITS;

    logic          vx, vy, rnz_x, rnz_y;
    logic [QW-1:0] q_x, q_y;
    logic [SW-1:0] side_x;
    logic          side_y;

    sint_div #(.NUW(NUW), .QW(QW), .SW(SW)) u_div_x (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ce          (ce),
        .in_valid    (f_ctrl.valid),
        .in_dividend (dvd_x),
        .in_den      (f_den),
        .in_side     ({f_ax, f_ay, f_ctrl.neg_x, f_ctrl.bad}),
        .out_valid   (vx),
        .out_q       (q_x),
        .out_rem_nz  (rnz_x),
        .out_side    (side_x)
    );

    sint_div #(.NUW(NUW), .QW(QW), .SW(1)) u_div_y (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ce          (ce),
        .in_valid    (f_ctrl.valid),
        .in_dividend (dvd_y),
        .in_den      (f_den),
        .in_side     (f_ctrl.neg_y),
        .out_valid   (vy),
        .out_q       (q_y),
        .out_rem_nz  (rnz_y),
        .out_side    (side_y)
    );

    logic signed [C-1:0] r_ax, r_ay;
    logic r_neg_x, r_bad;
    assign {r_ax, r_ay, r_neg_x, r_bad} = side_x;

    logic signed [EW-1:0] base_x, base_y, sum_x, sum_y, k_x, k_y;
    assign base_x = EW'(r_ax) <<< FRAC_BITS;
    assign base_y = EW'(r_ay) <<< FRAC_BITS;
    assign sum_x = r_neg_x ? base_x - EW'(q_x) : base_x + EW'(q_x);
    assign sum_y = side_y  ? base_y - EW'(q_y) : base_y + EW'(q_y);

    // truncate toward zero
    always_comb begin
        k_x = sum_x;
        if (rnz_x && !r_neg_x && sum_x < 0) k_x = sum_x + EW'(1);
        if (rnz_x && r_neg_x && sum_x > 0)  k_x = sum_x - EW'(1);
        k_y = sum_y;
        if (rnz_y && !side_y && sum_y < 0)  k_y = sum_y + EW'(1);
        if (rnz_y && side_y && sum_y > 0)   k_y = sum_y - EW'(1);
    end

    logic          m_tvalid_reg, hit_reg;
    logic [OW-1:0] hx_reg, hy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= vx && vy;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            hit_reg <= !r_bad;
            hx_reg  <= r_bad ? '0 : k_x[OW-1:0];
            hy_reg  <= r_bad ? '0 : k_y[OW-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = TW'({hy_reg, hx_reg});

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_nohit_zero, aclk, aresetn, m_tvalid && !m_tuser,
                    hx_reg == '0 && hy_reg == '0)
    `ASSERT_IMPLIES(a_lanes_aligned, aclk, aresetn, 1'b1, vx == vy)
    `ASSERT_IMPLIES(a_reset_empty, aclk, aresetn, $past(!aresetn), !m_tvalid)
endmodule

### tb/segment_intersection_2d_checker.sv
// checker for the segment intersection block: watches both channels, predicts and compares
// depends on segment_intersection_2d port widths at default parameters
`timescale 1ns / 1ps
module segment_intersection_2d_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending
);
    typedef struct packed {
        logic               hit;
        logic signed [23:0] hx;
        logic signed [23:0] hy;
    } crossing_t;

    crossing_t crossings_due[$];

    assign pending = crossings_due.size();

    // a*2^8 + delta*num/den, truncated toward zero
    function automatic logic signed [23:0] place_coord(longint a, longint delta,
                                                       longint num, longint den);
        logic signed [127:0] full;
        logic signed [127:0] q;
        full = (128'(signed'(a)) <<< 8) * 128'(signed'(den))
             + (128'(signed'(delta)) <<< 8) * 128'(signed'(num));
        q = full / 128'(signed'(den));
        return q[23:0];
    endfunction

    function automatic crossing_t predict_crossing(logic [127:0] d);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint ux, uy, vx, vy, wx, wy, crc, crd, num, den;
        crossing_t r;
        ax = longint'($signed(d[15:0]));    ay = longint'($signed(d[31:16]));
        bx = longint'($signed(d[47:32]));   by = longint'($signed(d[63:48]));
        cx = longint'($signed(d[79:64]));   cy = longint'($signed(d[95:80]));
        dx = longint'($signed(d[111:96]));  dy = longint'($signed(d[127:112]));
        r = '0;
        if ((ax == bx && ay == by) || (cx == dx && cy == dy)) return r;
        if ((ax == cx && ay == cy) || (bx == cx && by == cy) ||
            (ax == dx && ay == dy) || (bx == dx && by == dy)) return r;
        ux = bx - ax; uy = by - ay;
        vx = cx - ax; vy = cy - ay;
        wx = dx - ax; wy = dy - ay;
        crc = ux * vy - uy * vx;
        crd = ux * wy - uy * wx;
        if ((crc < 0) == (crd < 0)) return r;
        num = vx * wy - vy * wx;
        den = crd - crc;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num < 0 || num > den) return r;
        r.hit = 1'b1;
        r.hx = place_coord(ax, ux, num, den);
        r.hy = place_coord(ay, uy, num, den);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("error at %0t: %s", $time, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        crossing_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                crossings_due.push_back(predict_crossing(s_tdata));
            if (m_tvalid && m_tready) begin
                if (crossings_due.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = crossings_due.pop_front();
                    if (m_tuser !== want.hit)
                        report_mismatch($sformatf("hit %b, expected %b", m_tuser, want.hit));
                    if (m_tdata[23:0] !== want.hx)
                        report_mismatch($sformatf("hit_x %0d, expected %0d",
                                        $signed(m_tdata[23:0]), want.hx));
                    if (m_tdata[47:24] !== want.hy)
                        report_mismatch($sformatf("hit_y %0d, expected %0d",
                                        $signed(m_tdata[47:24]), want.hy));
                end
            end
        end
    end
endmodule

### tb/segment_intersection_2d_tb.sv
// testbench top for segment_intersection_2d: drives queries with random idling and stalls
// uses segment_intersection_2d and segment_intersection_2d_checker
`timescale 1ns / 1ps
module segment_intersection_2d_tb;
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           hold_off = 1'b0;
    longint       cycle_count = 0;

    always #1 aclk = ~aclk;

    segment_intersection_2d DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    segment_intersection_2d_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("segment_intersection_2d: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [127:0] pack_query(int ax, int ay, int bx, int by,
                                                int cx, int cy, int dx, int dy);
        return {16'(dy), 16'(dx), 16'(cy), 16'(cx), 16'(by), 16'(bx), 16'(ay), 16'(ax)};
    endfunction

    // mostly crossing pairs built around a shared point, some plain noise
    function automatic logic [127:0] random_query();
        int px, py, k;
        logic [127:0] q;
        k = $urandom_range(9);
        if (k < 2) begin
            for (int i = 0; i < 8; i++) q[i*16 +: 16] = rand_coord();
            return q;
        end
        px = $signed(16'($urandom)) / 2;
        py = $signed(16'($urandom)) / 2;
        if (k < 4) begin
            px = $signed($urandom_range(40)) - 20;
            py = $signed($urandom_range(40)) - 20;
            return pack_query(px - $urandom_range(20), py - $urandom_range(20),
                              px + $urandom_range(20), py + $urandom_range(20),
                              px - $urandom_range(20), py + $urandom_range(20),
                              px + $urandom_range(20), py - $urandom_range(20));
        end
        return pack_query(px - $urandom_range(16000), py - $urandom_range(16000),
                          px + $urandom_range(16000), py + $urandom_range(16000),
                          px - $urandom_range(16000), py + $urandom_range(16000),
                          px + $urandom_range(16000), py - $urandom_range(16000));
    endfunction

    task automatic send_query(logic [127:0] q);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= q;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: crossings, end touches, degenerate and extreme cases
        send_query(pack_query(0, 0, 4, 4, 0, 4, 4, 0));
        send_query(pack_query(0, 0, 4, 0, 2, 0, 2, 5));
        send_query(pack_query(0, 0, 4, 0, 4, -3, 4, 5));
        send_query(pack_query(0, 0, 4, 0, 0, -3, 0, 5));
        send_query(pack_query(0, 0, 4, 0, 5, -3, 5, 5));
        send_query(pack_query(1, 1, 1, 1, 0, 4, 4, 0));
        send_query(pack_query(0, 0, 4, 4, 3, 3, 3, 3));
        send_query(pack_query(0, 0, 4, 4, 0, 0, 4, 0));
        send_query(pack_query(0, 0, 4, 4, 4, 4, 0, 3));
        send_query(pack_query(0, 0, 4, 4, 1, 1, 6, 6));
        send_query(pack_query(0, 0, 4, 4, 0, 1, 4, 5));
        send_query(pack_query(0, 0, 3, 1, 0, 1, 1, 0));
        send_query(pack_query(-1, -1, -4, -3, -3, -1, -1, -4));
        send_query(pack_query(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_query(pack_query(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_query(pack_query(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        send_query(pack_query(0, 0, 7, 3, 5, -32768, 2, 32767));
        send_query({128{1'b1}});
        send_query({8{16'h5555}} ^ {64'h0, {4{16'hffff}}});
        wait_drained();

        // receiver holds off long while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (80) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++) send_query(random_query());
        join
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int i = 0; i < 360; i++) send_query(random_query());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (60) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("segment_intersection_2d: match");
        else
            $display("segment_intersection_2d: mismatch");
        $finish;
    end
endmodule
